// File: rtl/core/rid_loc_pkg.sv
package rid_loc_pkg;

    // Reciprocal constants for division by a constant: q = (x * M) >> K.
    // Each one is exact over the operand range that reaches it.
    localparam logic [16:0] DEG_RECIP   = 17'd83887;     // /100, K = 23
    localparam int          DEG_SHIFT   = 23;
    localparam logic [14:0] SPD0_RECIP  = 15'd20972;     // /25,  K = 19
    localparam int          SPD0_SHIFT  = 19;
    localparam logic [14:0] SPD1_RECIP  = 15'd27963;     // /75,  K = 21
    localparam int          SPD1_SHIFT  = 21;
    localparam logic [12:0] VS_RECIP    = 13'd5243;      // /50,  K = 18
    localparam int          VS_SHIFT    = 18;
    localparam logic [21:0] PA_RECIP    = 22'd2684355;   // /50,  K = 27
    localparam int          PA_SHIFT    = 27;
    localparam logic [23:0] GA_RECIP    = 24'd10737419;  // /100, K = 30
    localparam int          GA_SHIFT    = 30;

    // Ground speed break points in cm/s.
    localparam logic [14:0] SPD_KNEE    = 15'd5625;
    localparam logic [14:0] SPD_TOP     = 15'd25425;
    localparam logic [8:0]  SPD_MAX     = 9'd254;

    localparam logic [12:0] VS_LIMIT    = 13'd6350;

    localparam logic signed [24:0] PA_LOW   = -25'sd100000;
    localparam logic signed [24:0] PA_HIGH  = 25'sd3176750;
    localparam logic [21:0]        PA_SPAN  = 22'd3276750;

    localparam logic [16:0] GA_M_NEG_MAX = 17'd1000;
    localparam logic [16:0] GA_M_POS_MAX = 17'd31767;

    localparam logic [9:0]  DEG_FULL    = 10'd360;
    localparam logic [9:0]  DEG_HALF    = 10'd180;

    // Accuracy thresholds in cm, ascending.
    localparam logic signed [22:0] VERT_LIM [6] = '{
        23'sd100, 23'sd300, 23'sd1000, 23'sd2500, 23'sd4500, 23'sd15000
    };
    localparam logic signed [22:0] HORIZ_LIM [12] = '{
        23'sd100, 23'sd300, 23'sd1000, 23'sd3000, 23'sd9260, 23'sd18520,
        23'sd55560, 23'sd92600, 23'sd185200, 23'sd370400, 23'sd740800,
        23'sd1852000
    };

    typedef struct packed {
        logic [15:0]        course_cdeg;
        logic signed [15:0] ground_speed_cms;
        logic signed [15:0] vertical_speed_cms;
        logic signed [23:0] pressure_alt_cm;
        logic signed [23:0] geodetic_alt_cm;
        logic signed [22:0] vert_acc_cm;
        logic               vert_acc_valid;
        logic signed [22:0] horiz_acc_cm;
        logic               horiz_acc_valid;
    } t_in;

    // After range clamping and offsetting.
    typedef struct packed {
        logic [16:0] cdeg_rnd;
        logic        spd_hi;
        logic        spd_sat;
        logic [14:0] spd_num;
        logic        vs_neg;
        logic [12:0] vs_abs;
        logic [21:0] pa_off;
        logic        ga_neg;
        logic [23:0] ga_abs;
        logic [2:0]  vacc;
        logic [3:0]  hacc;
    } t_s1;

    // After the constant divisions.
    typedef struct packed {
        logic [9:0]  deg;
        logic        spd_hi;
        logic        spd_sat;
        logic [8:0]  spd_q;
        logic        vs_neg;
        logic [6:0]  vs_q;
        logic [15:0] pa_q;
        logic        ga_neg;
        logic [16:0] ga_q;
        logic [2:0]  vacc;
        logic [3:0]  hacc;
    } t_s2;

    typedef struct packed {
        logic        ew_west;
        logic [7:0]  track_dir;
        logic        speed_mult;
        logic [7:0]  speed_code;
        logic [7:0]  vspeed_code;
        logic [15:0] pressure_alt_code;
        logic [15:0] geodetic_alt_code;
        logic [2:0]  vert_acc_code;
        logic [3:0]  horiz_acc_code;
    } t_out;

    // The code equals the number of thresholds lying above the value, or 0 if invalid or negative.
    function automatic logic [2:0] vert_code(input logic signed [22:0] a,
                                             input logic v);
        logic [2:0] c;
        c = '0;
        for (int i = 0; i < 6; i++) begin
            if (a < VERT_LIM[i]) begin
                c = c + 3'd1;
            end
        end
        return (v && !a[22]) ? c : 3'd0;
    endfunction

    function automatic logic [3:0] horiz_code(input logic signed [22:0] a,
                                              input logic v);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 12; i++) begin
            if (a < HORIZ_LIM[i]) begin
                c = c + 4'd1;
            end
        end
        return (v && !a[22]) ? c : 4'd0;
    endfunction

endpackage

// File: rtl/core/rid_loc_prep.sv
module rid_loc_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rid_loc_pkg::t_in  i_data,
    output logic              o_ready,
    output logic              o_valid,
    output rid_loc_pkg::t_s1  o_data,
    input  logic              i_ready
);
    import rid_loc_pkg::*;

    logic               r_valid;
    t_s1                r_data;
    t_s1                n_data;
    logic [14:0]        spd_v;
    logic signed [24:0] pa_ext;
    logic signed [24:0] pa_sum;
    logic [15:0]        vs_mag;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data = '0;
        n_data.cdeg_rnd = 17'(i_data.course_cdeg) + 17'd50;

        spd_v = i_data.ground_speed_cms[15] ? 15'd0 : i_data.ground_speed_cms[14:0];
        n_data.spd_hi  = spd_v > SPD_KNEE;
        n_data.spd_sat = spd_v >= SPD_TOP;
        n_data.spd_num = n_data.spd_hi ? (spd_v - SPD_KNEE) : spd_v;

        vs_mag = 16'(-i_data.vertical_speed_cms);
        n_data.vs_neg = i_data.vertical_speed_cms[15];
        if (i_data.vertical_speed_cms > $signed({3'b000, VS_LIMIT})) begin
            n_data.vs_abs = VS_LIMIT;
        end else if (i_data.vertical_speed_cms < -$signed({3'b000, VS_LIMIT})) begin
            n_data.vs_abs = VS_LIMIT;
        end else if (n_data.vs_neg) begin
            n_data.vs_abs = vs_mag[12:0];
        end else begin
            n_data.vs_abs = i_data.vertical_speed_cms[12:0];
        end

        pa_ext = 25'(i_data.pressure_alt_cm);
        pa_sum = pa_ext - PA_LOW;
        if (pa_ext < PA_LOW) begin
            n_data.pa_off = '0;
        end else if (pa_ext > PA_HIGH) begin
            n_data.pa_off = PA_SPAN;
        end else begin
            n_data.pa_off = pa_sum[21:0];
        end

        n_data.ga_neg = i_data.geodetic_alt_cm[23];
        n_data.ga_abs = n_data.ga_neg ? 24'(-i_data.geodetic_alt_cm)
                                      : i_data.geodetic_alt_cm;

        n_data.vacc = vert_code(i_data.vert_acc_cm, i_data.vert_acc_valid);
        n_data.hacc = horiz_code(i_data.horiz_acc_cm, i_data.horiz_acc_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/rid_loc_div.sv
module rid_loc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rid_loc_pkg::t_s1  i_data,
    output logic              o_ready,
    output logic              o_valid,
    output rid_loc_pkg::t_s2  o_data,
    input  logic              i_ready
);
    import rid_loc_pkg::*;

    logic        r_valid;
    t_s2         r_data;
    t_s2         n_data;
    logic [33:0] deg_p;
    logic [29:0] spd_p;
    logic [25:0] vs_p;
    logic [43:0] pa_p;
    logic [47:0] ga_p;

    assign o_ready = !r_valid || i_ready;

    // Each division is a multiply by a scaled reciprocal and a fixed shift.
    always_comb begin
        deg_p = 34'(i_data.cdeg_rnd) * 34'(DEG_RECIP);
        spd_p = 30'(i_data.spd_num) * 30'(i_data.spd_hi ? SPD1_RECIP : SPD0_RECIP);
        vs_p  = 26'(i_data.vs_abs) * 26'(VS_RECIP);
        pa_p  = 44'(i_data.pa_off) * 44'(PA_RECIP);
        ga_p  = 48'(i_data.ga_abs) * 48'(GA_RECIP);

        n_data         = '0;
        n_data.deg     = deg_p[DEG_SHIFT +: 10];
        n_data.spd_hi  = i_data.spd_hi;
        n_data.spd_sat = i_data.spd_sat;
        n_data.spd_q   = i_data.spd_hi ? spd_p[SPD1_SHIFT +: 9] : spd_p[SPD0_SHIFT +: 9];
        n_data.vs_neg  = i_data.vs_neg;
        n_data.vs_q    = vs_p[VS_SHIFT +: 7];
        n_data.pa_q    = pa_p[PA_SHIFT +: 16];
        n_data.ga_neg  = i_data.ga_neg;
        n_data.ga_q    = ga_p[GA_SHIFT +: 17];
        n_data.vacc    = i_data.vacc;
        n_data.hacc    = i_data.hacc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/rid_loc_pack.sv
module rid_loc_pack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rid_loc_pkg::t_s2  i_data,
    output logic              o_ready,
    output logic              o_valid,
    output rid_loc_pkg::t_out o_data,
    input  logic              i_ready
);
    import rid_loc_pkg::*;

    logic        r_valid;
    t_out        r_data;
    t_out        n_data;
    logic [9:0]  deg_w;
    logic [9:0]  deg_h;
    logic [8:0]  spd_c;
    logic [7:0]  vs_c;
    logic [16:0] ga_m;
    logic [15:0] ga_base;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // Rounded degrees stay below 720, so one subtraction wraps them.
        deg_w = (i_data.deg >= DEG_FULL) ? (i_data.deg - DEG_FULL) : i_data.deg;
        deg_h = (deg_w >= DEG_HALF) ? (deg_w - DEG_HALF) : deg_w;

        spd_c = (i_data.spd_sat || i_data.spd_q > SPD_MAX) ? SPD_MAX : i_data.spd_q;

        vs_c = i_data.vs_neg ? 8'(-{1'b0, i_data.vs_q}) : {1'b0, i_data.vs_q};

        // Whole metres, clamped to the coded range, then offset by 1000 m.
        if (i_data.ga_neg) begin
            ga_m    = (i_data.ga_q > GA_M_NEG_MAX) ? GA_M_NEG_MAX : i_data.ga_q;
            ga_base = 16'(GA_M_NEG_MAX - ga_m);
        end else begin
            ga_m    = (i_data.ga_q > GA_M_POS_MAX) ? GA_M_POS_MAX : i_data.ga_q;
            ga_base = 16'(ga_m + GA_M_NEG_MAX);
        end

        n_data                   = '0;
        n_data.ew_west           = deg_w >= DEG_HALF;
        n_data.track_dir         = deg_h[7:0];
        n_data.speed_mult        = i_data.spd_hi;
        n_data.speed_code        = spd_c[7:0];
        n_data.vspeed_code       = vs_c;
        n_data.pressure_alt_code = i_data.pa_q;
        n_data.geodetic_alt_code = {ga_base[14:0], 1'b0};
        n_data.vert_acc_code     = i_data.vacc;
        n_data.horiz_acc_code    = i_data.hacc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/remote_id_location_field_encoder.sv
// Path: an accepted input passes three register stages in turn, one item per stage.
// Throughput: one transaction per cycle while m_axis_tready is high; the rate is set
// by the register pipeline stages: clamp, reciprocal multiply, final coding.
// Reset: i_rst_n is synchronous and active low; it clears all stage valid bits,
// so the pipeline comes up empty with s_axis_tready high and m_axis_tvalid low.
module remote_id_location_field_encoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // From bit 0 up: course_cdeg[16], ground_speed_cms[16], vertical_speed_cms[16],
    // pressure_alt_cm[24], geodetic_alt_cm[24], vert_acc_cm[23], vert_acc_valid[1],
    // horiz_acc_cm[23], horiz_acc_valid[1].
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // From bit 0 up: ew_west[1], track_dir[8], speed_mult[1], speed_code[8],
    // vspeed_code[8], pressure_alt_code[16], geodetic_alt_code[16],
    // vert_acc_code[3], horiz_acc_code[4], then seven zero bits.
    output logic [71:0]  m_axis_tdata
);
    import rid_loc_pkg::*;

    // Each stage holds its item until the next stage can take it. A stage
    // with an empty register always accepts, so bubbles are squeezed out and
    // the input keeps flowing while a finished result waits at the output,
    // until the first two stages hold items as well.

    t_in  in_data;
    t_s1  s1_data;
    t_s2  s2_data;
    t_out s3_data;
    logic s1_valid;
    logic s2_valid;
    logic s1_ready;
    logic s2_ready;

    // Unpack the input transaction into its fields.
    always_comb begin
        in_data.course_cdeg        = s_axis_tdata[15:0];
        in_data.ground_speed_cms   = s_axis_tdata[31:16];
        in_data.vertical_speed_cms = s_axis_tdata[47:32];
        in_data.pressure_alt_cm    = s_axis_tdata[71:48];
        in_data.geodetic_alt_cm    = s_axis_tdata[95:72];
        in_data.vert_acc_cm        = s_axis_tdata[118:96];
        in_data.vert_acc_valid     = s_axis_tdata[119];
        in_data.horiz_acc_cm       = s_axis_tdata[142:120];
        in_data.horiz_acc_valid    = s_axis_tdata[143];
    end

    // Stage one clamps the speeds and pressure altitude and removes offsets.
    // The accuracy codes are also settled here, as they need only compares.
    rid_loc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_data  (in_data),
        .o_ready (s_axis_tready),
        .o_valid (s1_valid),
        .o_data  (s1_data),
        .i_ready (s1_ready)
    );

    // Stage two performs every constant division as a reciprocal multiply.
    rid_loc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_ready (s1_ready),
        .o_valid (s2_valid),
        .o_data  (s2_data),
        .i_ready (s2_ready)
    );

    // Stage three wraps the course, saturates the speed, restores signs and
    // forms the altitude codes; its register is the output register.
    rid_loc_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_data  (s2_data),
        .o_ready (s2_ready),
        .o_valid (m_axis_tvalid),
        .o_data  (s3_data),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {
        7'd0,
        s3_data.horiz_acc_code,
        s3_data.vert_acc_code,
        s3_data.geodetic_alt_code,
        s3_data.pressure_alt_code,
        s3_data.vspeed_code,
        s3_data.speed_code,
        s3_data.speed_mult,
        s3_data.track_dir,
        s3_data.ew_west
    };

endmodule
